@@ rtl/sqh_pkg.sv @@
// Package with the shared types and constants of the trace classifier.
package sqh_pkg;

    // Store geometry and value width.
    localparam int DEPTH      = 256;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int VALUE_BITS = 16;

    // Trace commands.
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Verdict codes.
    typedef enum logic [2:0] {
        VERDICT_IMPOSSIBLE = 3'd0,
        VERDICT_STACK      = 3'd1,
        VERDICT_QUEUE      = 3'd2,
        VERDICT_PRIO       = 3'd3,
        VERDICT_UNSURE     = 3'd4
    } t_verdict;

    // One input item.
    typedef struct packed {
        t_cmd                  command;
        logic [VALUE_BITS-1:0] value;
        logic                  first_of_trace;
    } t_item;

    // One result item.
    typedef struct packed {
        logic     can_be_stack;
        logic     can_be_queue;
        logic     can_be_priority_queue;
        t_verdict verdict;
        logic     overflow;
    } t_result;

    // Top level sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HEAP,
        S_DONE
    } t_state;

    // Heap operations.
    typedef enum logic {
        HOP_INSERT = 1'b0,
        HOP_REMOVE = 1'b1
    } t_heap_op;

    // Heap unit sequencer states.
    typedef enum logic [3:0] {
        H_IDLE,
        H_INS_RD,
        H_INS_CMP,
        H_REM_TOP,
        H_REM_LAST,
        H_REM_GET,
        H_REM_CHK,
        H_REM_L,
        H_REM_R,
        H_REM_CMP
    } t_hstate;

    // Request from the top level to the heap unit.
    typedef struct packed {
        logic                  start;
        t_heap_op              op;
        logic [ADDR_W-1:0]     count;
        logic [VALUE_BITS-1:0] value;
    } t_heap_req;

    // Status from the heap unit.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] top;
    } t_heap_stat;

endpackage

@@ rtl/stack_queue_heap_trace_classifier_core.sv @@
// Top level of the stack, queue and priority queue trace classifier.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-----------------------------------------
//  item in  | i_start, i_item, o_busy   | taken at an edge with i_start high, o_busy low
//  result   | o_done, o_result          | one-cycle strobe, always taken
//
// A push or a pop hands its work to the heap sift loop, which walks at most log2 of the
// depth heap levels and reads one heap node at a time through the heap memory read port;
// an overflowing push or an empty pop goes straight to the result and skips the heap.
// Reset clears the entry count, the queue pointers and the stack, queue and heap flags;
// the stores need no clearing pass. The result strobe is not stalled; o_busy stays high until the result is shown.
module stack_queue_heap_trace_classifier_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sqh_pkg::t_item   i_item,
    output logic             o_busy,
    output logic             o_done,
    output sqh_pkg::t_result o_result
);

    sqh_pkg::t_state r_state, n_state;
    sqh_pkg::t_cmd   r_cmd, n_cmd;
    logic [sqh_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic [sqh_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [sqh_pkg::ADDR_W-1:0]     r_head, n_head;
    logic [sqh_pkg::ADDR_W-1:0]     r_tail, n_tail;
    logic r_stack_ok, n_stack_ok;
    logic r_queue_ok, n_queue_ok;
    logic r_heap_ok, n_heap_ok;
    logic r_ovf, n_ovf;

    logic                accept;
    logic                full, empty;
    sqh_pkg::t_heap_req  heap_req;
    sqh_pkg::t_heap_stat heap_stat;

    // Stack and queue memories with registered reads.
    logic [sqh_pkg::VALUE_BITS-1:0] stack_mem [sqh_pkg::DEPTH];
    logic [sqh_pkg::VALUE_BITS-1:0] fifo_mem [sqh_pkg::DEPTH];
    logic [sqh_pkg::VALUE_BITS-1:0] r_stack_rd, r_fifo_rd;
    logic                           mem_we, mem_re;
    logic [sqh_pkg::ADDR_W-1:0]     stack_addr;

    assign accept = i_start && (r_state == sqh_pkg::S_IDLE);
    assign full   = (r_cnt == sqh_pkg::CNT_W'(sqh_pkg::DEPTH));
    assign empty  = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            stack_mem[stack_addr] <= r_val;
            fifo_mem[r_tail]      <= r_val;
        end
        if (mem_re) begin
            r_stack_rd <= stack_mem[stack_addr];
            r_fifo_rd  <= fifo_mem[r_head];
        end
    end

    sqh_heap_unit u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (heap_req),
        .o_stat  (heap_stat)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqh_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = sqh_pkg::S_EXEC;
                end
            end
            sqh_pkg::S_EXEC: begin
                if (r_cmd == sqh_pkg::CMD_PUSH) begin
                    n_state = full ? sqh_pkg::S_DONE : sqh_pkg::S_HEAP;
                end else begin
                    n_state = empty ? sqh_pkg::S_DONE : sqh_pkg::S_HEAP;
                end
            end
            sqh_pkg::S_HEAP: begin
                if (heap_stat.done) begin
                    n_state = sqh_pkg::S_DONE;
                end
            end
            sqh_pkg::S_DONE: n_state = sqh_pkg::S_IDLE;
            default:         n_state = sqh_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_cnt      = r_cnt;
        n_head     = r_head;
        n_tail     = r_tail;
        n_stack_ok = r_stack_ok;
        n_queue_ok = r_queue_ok;
        n_heap_ok  = r_heap_ok;
        n_ovf      = r_ovf;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        stack_addr = r_cnt[sqh_pkg::ADDR_W-1:0];
        heap_req.start = 1'b0;
        heap_req.op    = sqh_pkg::HOP_INSERT;
        heap_req.count = r_cnt[sqh_pkg::ADDR_W-1:0];
        heap_req.value = r_val;
        unique case (r_state)
            // Latch the item; a first item of a trace empties the stores.
            sqh_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_item.command;
                    n_val = i_item.value;
                    n_ovf = 1'b0;
                    if (i_item.first_of_trace) begin
                        n_cnt      = '0;
                        n_head     = '0;
                        n_tail     = '0;
                        n_stack_ok = 1'b1;
                        n_queue_ok = 1'b1;
                        n_heap_ok  = 1'b1;
                    end
                end
            end
            // Update the stack and queue and hand the heap its work.
            sqh_pkg::S_EXEC: begin
                if (r_cmd == sqh_pkg::CMD_PUSH) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we         = 1'b1;
                        n_tail         = (r_tail == sqh_pkg::ADDR_W'(sqh_pkg::DEPTH - 1))
                                         ? '0 : r_tail + sqh_pkg::ADDR_W'(1);
                        n_cnt          = r_cnt + sqh_pkg::CNT_W'(1);
                        heap_req.start = 1'b1;
                    end
                end else begin
                    if (empty) begin
                        n_stack_ok = 1'b0;
                        n_queue_ok = 1'b0;
                        n_heap_ok  = 1'b0;
                    end else begin
                        mem_re         = 1'b1;
                        n_cnt          = r_cnt - sqh_pkg::CNT_W'(1);
                        stack_addr     = n_cnt[sqh_pkg::ADDR_W-1:0];
                        n_head         = (r_head == sqh_pkg::ADDR_W'(sqh_pkg::DEPTH - 1))
                                         ? '0 : r_head + sqh_pkg::ADDR_W'(1);
                        heap_req.start = 1'b1;
                        heap_req.op    = sqh_pkg::HOP_REMOVE;
                        heap_req.count = n_cnt[sqh_pkg::ADDR_W-1:0];
                    end
                end
            end
            // A pop clears the flag of every store whose head differs.
            sqh_pkg::S_HEAP: begin
                if (heap_stat.done && (r_cmd == sqh_pkg::CMD_POP)) begin
                    n_stack_ok = r_stack_ok && (r_stack_rd == r_val);
                    n_queue_ok = r_queue_ok && (r_fifo_rd == r_val);
                    n_heap_ok  = r_heap_ok && (heap_stat.top == r_val);
                end
            end
            sqh_pkg::S_DONE: begin
                n_ovf = r_ovf;
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sqh_pkg::S_IDLE;
            r_cnt      <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_stack_ok <= 1'b1;
            r_queue_ok <= 1'b1;
            r_heap_ok  <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_stack_ok <= n_stack_ok;
            r_queue_ok <= n_queue_ok;
            r_heap_ok  <= n_heap_ok;
        end
        r_cmd <= n_cmd;
        r_val <= n_val;
        r_ovf <= n_ovf;
    end

    // Result: flags and the verdict derived from them.
    always_comb begin
        o_result.can_be_stack          = r_stack_ok;
        o_result.can_be_queue          = r_queue_ok;
        o_result.can_be_priority_queue = r_heap_ok;
        o_result.overflow              = r_ovf;
        case ({r_stack_ok, r_queue_ok, r_heap_ok})
            3'b000:  o_result.verdict = sqh_pkg::VERDICT_IMPOSSIBLE;
            3'b100:  o_result.verdict = sqh_pkg::VERDICT_STACK;
            3'b010:  o_result.verdict = sqh_pkg::VERDICT_QUEUE;
            3'b001:  o_result.verdict = sqh_pkg::VERDICT_PRIO;
            default: o_result.verdict = sqh_pkg::VERDICT_UNSURE;
        endcase
    end

    assign o_busy = (r_state != sqh_pkg::S_IDLE);
    assign o_done = (r_state == sqh_pkg::S_DONE);

`ifndef SYNTH
    // The entry count never exceeds the store depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sqh_pkg::CNT_W'(sqh_pkg::DEPTH))
        else $error("entry count beyond depth");

    // An overflow is reported only for a push on full stores.
    a_ovf_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.overflow) |-> (r_cmd == sqh_pkg::CMD_PUSH) && full)
        else $error("overflow without a full push");

    // A cleared stack flag comes back only through a first item of a trace.
    a_flag_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stack_ok) |-> $past(accept && i_item.first_of_trace))
        else $error("stack flag set without a new trace");

    // The heap unit is never busy while the sequencer is idle.
    a_heap_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sqh_pkg::S_IDLE) |-> !heap_stat.busy)
        else $error("heap unit busy while idle");
`endif

endmodule

@@ rtl/sqh_heap_unit.sv @@
// Max-heap store with a sift sequencer around one shared comparator.
module sqh_heap_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sqh_pkg::t_heap_req  i_req,
    output sqh_pkg::t_heap_stat o_stat
);

    sqh_pkg::t_hstate r_state, n_state;
    logic [sqh_pkg::ADDR_W-1:0]     r_i, n_i;
    logic [sqh_pkg::ADDR_W-1:0]     r_n, n_n;
    logic [sqh_pkg::VALUE_BITS-1:0] r_v, n_v;
    logic [sqh_pkg::VALUE_BITS-1:0] r_big, n_big;
    logic [sqh_pkg::ADDR_W-1:0]     r_bigidx, n_bigidx;
    logic [sqh_pkg::VALUE_BITS-1:0] r_top, n_top;
    logic                           r_done, n_done;

    // Heap memory with a registered read port.
    logic [sqh_pkg::VALUE_BITS-1:0] mem [sqh_pkg::DEPTH];
    logic [sqh_pkg::VALUE_BITS-1:0] r_rd;
    logic                           rd_en, wr_en;
    logic [sqh_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
    logic [sqh_pkg::VALUE_BITS-1:0] wr_data;

    // Shared comparator.
    logic [sqh_pkg::VALUE_BITS-1:0] cmp_a, cmp_b;
    logic                           cmp_ge;

    // Child and parent positions of the current node.
    logic [sqh_pkg::CNT_W-1:0]  c_left, c_right;
    logic [sqh_pkg::ADDR_W-1:0] c_parent;
    logic                       left_out, right_in;

    assign c_left   = {r_i, 1'b1};
    assign c_right  = c_left + sqh_pkg::CNT_W'(1);
    assign c_parent = (r_i - sqh_pkg::ADDR_W'(1)) >> 1;
    assign left_out = c_left >= {1'b0, r_n};
    assign right_in = c_right < {1'b0, r_n};
    assign cmp_ge   = cmp_a >= cmp_b;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqh_pkg::H_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == sqh_pkg::HOP_INSERT) ? sqh_pkg::H_INS_RD
                                                                : sqh_pkg::H_REM_TOP;
                end
            end
            sqh_pkg::H_INS_RD: begin
                n_state = (r_i == '0) ? sqh_pkg::H_IDLE : sqh_pkg::H_INS_CMP;
            end
            sqh_pkg::H_INS_CMP: begin
                n_state = cmp_ge ? sqh_pkg::H_IDLE : sqh_pkg::H_INS_RD;
            end
            sqh_pkg::H_REM_TOP:  n_state = sqh_pkg::H_REM_LAST;
            sqh_pkg::H_REM_LAST: begin
                n_state = (r_n == '0) ? sqh_pkg::H_IDLE : sqh_pkg::H_REM_GET;
            end
            sqh_pkg::H_REM_GET: n_state = sqh_pkg::H_REM_CHK;
            sqh_pkg::H_REM_CHK: begin
                n_state = left_out ? sqh_pkg::H_IDLE : sqh_pkg::H_REM_L;
            end
            sqh_pkg::H_REM_L: begin
                n_state = right_in ? sqh_pkg::H_REM_R : sqh_pkg::H_REM_CMP;
            end
            sqh_pkg::H_REM_R:   n_state = sqh_pkg::H_REM_CMP;
            sqh_pkg::H_REM_CMP: begin
                n_state = cmp_ge ? sqh_pkg::H_IDLE : sqh_pkg::H_REM_CHK;
            end
            default: n_state = sqh_pkg::H_IDLE;
        endcase
    end

    // Datapath, memory control and comparator operands.
    always_comb begin
        n_i      = r_i;
        n_n      = r_n;
        n_v      = r_v;
        n_big    = r_big;
        n_bigidx = r_bigidx;
        n_top    = r_top;
        n_done   = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_i;
        wr_data  = r_v;
        cmp_a    = r_rd;
        cmp_b    = r_v;
        unique case (r_state)
            sqh_pkg::H_IDLE: begin
                if (i_req.start) begin
                    n_i = i_req.count;
                    n_n = i_req.count;
                    n_v = i_req.value;
                end
            end
            // Insert: walk up while the parent is smaller than the new value.
            sqh_pkg::H_INS_RD: begin
                if (r_i == '0) begin
                    wr_en  = 1'b1;
                    n_done = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = c_parent;
                end
            end
            sqh_pkg::H_INS_CMP: begin
                wr_en = 1'b1;
                if (cmp_ge) begin
                    n_done = 1'b1;
                end else begin
                    wr_data = r_rd;
                    n_i     = c_parent;
                end
            end
            // Remove: fetch the root, then the last entry.
            sqh_pkg::H_REM_TOP: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            sqh_pkg::H_REM_LAST: begin
                n_top = r_rd;
                if (r_n == '0) begin
                    n_done = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_n;
                end
            end
            sqh_pkg::H_REM_GET: begin
                n_v = r_rd;
                n_i = '0;
            end
            // Sift down: pick the larger child and move it up if it beats the last entry.
            sqh_pkg::H_REM_CHK: begin
                if (left_out) begin
                    wr_en  = 1'b1;
                    n_done = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = c_left[sqh_pkg::ADDR_W-1:0];
                end
            end
            sqh_pkg::H_REM_L: begin
                n_big    = r_rd;
                n_bigidx = c_left[sqh_pkg::ADDR_W-1:0];
                if (right_in) begin
                    rd_en   = 1'b1;
                    rd_addr = c_right[sqh_pkg::ADDR_W-1:0];
                end
            end
            sqh_pkg::H_REM_R: begin
                cmp_a = r_big;
                cmp_b = r_rd;
                if (!cmp_ge) begin
                    n_big    = r_rd;
                    n_bigidx = c_right[sqh_pkg::ADDR_W-1:0];
                end
            end
            sqh_pkg::H_REM_CMP: begin
                cmp_a = r_v;
                cmp_b = r_big;
                wr_en = 1'b1;
                if (cmp_ge) begin
                    n_done = 1'b1;
                end else begin
                    wr_data = r_big;
                    n_i     = r_bigidx;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqh_pkg::H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_i      <= n_i;
        r_n      <= n_n;
        r_v      <= n_v;
        r_big    <= n_big;
        r_bigidx <= n_bigidx;
        r_top    <= n_top;
    end

    assign o_stat.busy = (r_state != sqh_pkg::H_IDLE);
    assign o_stat.done = r_done;
    assign o_stat.top  = r_top;

endmodule
